### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define RSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define RSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Widths, limits, codes and shared types of the ramped-average sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

    localparam int CHANNELS       = 5;
    localparam int CH_W           = 3;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    localparam int SAMPLE_W       = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

    localparam int COUNT_W        = 12;
    localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(4095);

    localparam int ACC_W          = 28;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam int SUM_W          = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int WIN_W          = 4;
    localparam logic [WIN_W-1:0] WINDOW_LIMIT = WIN_W'(10);
    localparam logic [WIN_W-1:0] READY_WINDOW = WIN_W'(4);

    localparam int AVG_W          = 16;
    localparam int CFG_W          = 16;
    localparam logic [CFG_W-1:0] REGULATE_HIGH_RESET = 16'd65535;
    localparam logic [CFG_W-1:0] REGULATE_LOW_RESET  = 16'd0;
    localparam logic [CFG_W-1:0] DAC_CEILING_RESET   = 16'd4095;
    localparam logic [CFG_W-1:0] DAC_START_RESET     = 16'd0;
    localparam logic [CFG_W-1:0] FLOOR_RESET         = 16'd0;

    // shared divider
    localparam int DIV_NUM_W      = 28;
    localparam int DIV_DEN_W      = 12;
    localparam int DIV_CNT_W      = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);
    localparam logic [DIV_DEN_W-1:0] SIGNAL_DIVISOR = DIV_DEN_W'(10);

    // divide by ten as (x * ceil(2^23 / 10)) >> 23, exact for x < 2^22
    localparam int TENTH_W        = 20;
    localparam int TENTH_SHIFT    = 23;
    localparam logic [TENTH_W-1:0] TENTH_RECIP = TENTH_W'(838861);

    typedef enum logic [2:0] {
        CFG_REGULATE_HIGH         = 3'd0,
        CFG_REGULATE_LOW          = 3'd1,
        CFG_DAC_CEILING           = 3'd2,
        CFG_DAC_START             = 3'd3,
        CFG_ANODE_FLOOR           = 3'd4,
        CFG_CATHODE_FLOOR         = 3'd5,
        CFG_BLEEDER_ANODE_FLOOR   = 3'd6,
        CFG_BLEEDER_CATHODE_FLOOR = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_MSTART,
        ST_MWAIT,
        ST_RSTART,
        ST_RWAIT,
        ST_CLOSE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

### hdl/rsa_divider.sv
// ----------------------------------------------------------------------------
// rsa_divider
// Restoring divider, one quotient bit per cycle; zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_divider import rsa_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_NUM_W-1:0] work_reg, work_next;
    logic [DIV_DEN_W-1:0] den_reg,  den_next;
    logic [DIV_DEN_W-1:0] rem_reg,  rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0] shifted;
    logic [DIV_DEN_W:0] diff;
    logic               fits;

    always_comb begin
        shifted = {rem_reg, work_reg[DIV_NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};

        work_next = work_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (req.start) begin
            work_next = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = DIV_STEPS;
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            work_next = {work_reg[DIV_NUM_W-2:0], fits};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        work_reg <= work_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (den_reg == '0) ? '0 : work_reg;

endmodule

`default_nettype wire

### hdl/regulated_sampler_with_ramped_average.sv
// ----------------------------------------------------------------------------
// regulated_sampler_with_ramped_average
// DAC level regulator with five-channel averaging over a growing tick window.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: five samples, s_tuser: operation
//  m_       out  m_tvalid/m_tready  m_tdata: level + five averages,
//                                   m_tuser: report_valid, data_ready
//  cfg_     in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  Steps: a sample word is accepted, makes five passes through the shared
//  accumulate adder, then its result is loaded into the output register.
//  A tick runs five means through the shared 28-step restoring divider.
//  A tick that closes a window adds five more divisions by the window length
//  (the signal sum is first divided by ten with a reciprocal multiply).
//  s_tready is high only in the idle state; a result waiting in the output
//  register does not stop the next word being taken, but the block stalls
//  before loading its own result until the output register is free.
//  Reset (aresetn low, synchronous) clears all but payload at once; no sweep.
//
`default_nettype none

module regulated_sampler_with_ramped_average import rsa_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] signal_sample, [31:16] anode_sample, [47:32] cathode_sample,
    // [63:48] bleeder_anode_sample, [79:64] bleeder_cathode_sample
    input  wire logic [79:0] s_tdata,
    // [0] operation
    input  wire logic [0:0]  s_tuser,
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] dac_level, [31:16] signal_average, [47:32] anode_average,
    // [63:48] cathode_average, [79:64] bleeder_anode_average,
    // [95:80] bleeder_cathode_average
    output logic [95:0]      m_tdata,
    // [0] report_valid, [1] data_ready
    output logic [1:0]       m_tuser,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    // configuration registers (dac_start only matters at reset, which loads
    // its reset value, so it is not stored)
    logic [CFG_W-1:0] reg_high_reg, reg_high_next;
    logic [CFG_W-1:0] reg_low_reg,  reg_low_next;
    logic [CFG_W-1:0] ceiling_reg,  ceiling_next;
    logic [CFG_W-1:0] floor_reg  [CHANNELS-1];
    logic [CFG_W-1:0] floor_next [CHANNELS-1];

    // architectural state
    logic [CFG_W-1:0]   drive_reg,  drive_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [ACC_W-1:0]   acc_reg  [CHANNELS];
    logic [ACC_W-1:0]   acc_next [CHANNELS];
    logic [SUM_W-1:0]   ws_reg   [CHANNELS];
    logic [SUM_W-1:0]   ws_next  [CHANNELS];
    logic [AVG_W-1:0]   rep_reg  [CHANNELS];
    logic [AVG_W-1:0]   rep_next [CHANNELS];
    logic [WIN_W-1:0]   ticks_reg,  ticks_next;
    logic [WIN_W-1:0]   growth_reg, growth_next;
    logic [WIN_W-1:0]   cwin_reg,   cwin_next;
    logic               ready_reg,  ready_next;

    // per-word working registers
    logic [SAMPLE_W-1:0] smp_reg  [CHANNELS];
    logic [SAMPLE_W-1:0] smp_next [CHANNELS];
    logic [CH_W-1:0]     ch_reg,    ch_next;
    logic                valid_reg, valid_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [95:0] m_data_reg,  m_data_next;
    logic [1:0]  m_user_reg,  m_user_next;

    // shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    rsa_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------------------------------------------------------- datapath
    logic [SAMPLE_W-1:0]      sig_in;
    logic [ACC_W:0]           acc_sum;
    logic [ACC_W:0]           ws_sum;
    logic [AVG_W-1:0]         avg_sat;
    logic [SUM_W+TENTH_W-1:0] tenth_prod;
    logic [SUM_W-1:0]         sig_tenth;
    logic [1:0]               fidx;
    logic [WIN_W-1:0]         tick_dec;
    logic [WIN_W-1:0]         grow_inc;
    logic [WIN_W-1:0]         new_ticks;
    logic                     accept;
    logic                     out_free;

    always_comb begin
        sig_in   = s_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
        acc_sum  = {1'b0, acc_reg[ch_reg]} + {{(ACC_W+1-SAMPLE_W){1'b0}}, smp_reg[ch_reg]};
        ws_sum   = {{(ACC_W+1-SUM_W){1'b0}}, ws_reg[ch_reg]} + {1'b0, div_rsp.quot};
        avg_sat  = (|div_rsp.quot[DIV_NUM_W-1:AVG_W]) ? {AVG_W{1'b1}}
                                                      : div_rsp.quot[AVG_W-1:0];
        // signal window sum / 10
        tenth_prod = {{TENTH_W{1'b0}}, ws_reg[0]} * {{SUM_W{1'b0}}, TENTH_RECIP};
        sig_tenth  = SUM_W'(tenth_prod >> TENTH_SHIFT);
        fidx     = 2'(ch_reg - CH_W'(1));
        tick_dec = ticks_reg - WIN_W'(1);
        grow_inc = growth_reg + WIN_W'(1);
        accept   = s_tvalid && s_tready;
        out_free = !m_valid_reg || m_tready;
    end

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next    = state_reg;
        reg_high_next = reg_high_reg;
        reg_low_next  = reg_low_reg;
        ceiling_next  = ceiling_reg;
        floor_next    = floor_reg;
        drive_next    = drive_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        ws_next       = ws_reg;
        rep_next      = rep_reg;
        ticks_next    = ticks_reg;
        growth_next   = growth_reg;
        cwin_next     = cwin_reg;
        ready_next    = ready_reg;
        smp_next      = smp_reg;
        ch_next       = ch_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        new_ticks     = ticks_reg;

        s_tready      = (state_reg == ST_IDLE);

        div_req.start = 1'b0;
        div_req.num   = acc_reg[ch_reg];
        div_req.den   = count_reg;

        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REGULATE_HIGH:         reg_high_next = cfg_data;
                CFG_REGULATE_LOW:          reg_low_next  = cfg_data;
                CFG_DAC_CEILING:           ceiling_next  = cfg_data;
                CFG_DAC_START:             ;
                CFG_ANODE_FLOOR:           floor_next[0] = cfg_data;
                CFG_CATHODE_FLOOR:         floor_next[1] = cfg_data;
                CFG_BLEEDER_ANODE_FLOOR:   floor_next[2] = cfg_data;
                CFG_BLEEDER_CATHODE_FLOOR: floor_next[3] = cfg_data;
                default:                   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        smp_next[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W] & SAMPLE_MASK;
                    end
                    // one regulation step; down takes priority
                    if (sig_in > reg_high_reg) begin
                        if (drive_reg != '0) drive_next = drive_reg - CFG_W'(1);
                    end else if (sig_in < reg_low_reg) begin
                        if (drive_reg < ceiling_reg) drive_next = drive_reg + CFG_W'(1);
                    end
                    valid_next = 1'b0;
                    ch_next    = '0;
                    state_next = s_tuser[0] ? ST_MSTART : ST_ACC;
                end
            end

            // one channel per cycle through the shared adder
            ST_ACC: begin
                acc_next[ch_reg] = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                if (ch_reg == LAST_CH) begin
                    if (count_reg < MAX_SAMPLES) count_next = count_reg + COUNT_W'(1);
                    state_next = ST_OUT;
                end else begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end

            // mean of one channel: accumulator / sample count
            ST_MSTART: begin
                div_req.start = 1'b1;
                state_next    = ST_MWAIT;
            end

            ST_MWAIT: begin
                if (div_rsp.done) begin
                    ws_next[ch_reg]  = (ws_sum > {{(ACC_W+1-SUM_W){1'b0}}, SUM_MAX})
                                     ? SUM_MAX : ws_sum[SUM_W-1:0];
                    acc_next[ch_reg] = '0;
                    if (ch_reg == LAST_CH) begin
                        count_next = '0;
                        ticks_next = tick_dec;
                        ch_next    = '0;
                        state_next = (tick_dec == '0) ? ST_RSTART : ST_OUT;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_MSTART;
                    end
                end
            end

            // each channel divided by the window length; signal already / 10
            ST_RSTART: begin
                div_req.start = 1'b1;
                div_req.num   = (ch_reg == '0) ? DIV_NUM_W'(sig_tenth)
                                               : DIV_NUM_W'(ws_reg[ch_reg]);
                div_req.den   = DIV_DEN_W'(cwin_reg);
                state_next    = ST_RWAIT;
            end

            ST_RWAIT: begin
                if (div_rsp.done) begin
                    if (ch_reg == '0) begin
                        rep_next[0] = avg_sat;
                    end else begin
                        rep_next[ch_reg] = (avg_sat < floor_reg[fidx]) ? '0 : avg_sat;
                    end
                    if (ch_reg == LAST_CH) begin
                        state_next = ST_CLOSE;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_RSTART;
                    end
                end
            end

            // window closed: set the next window length
            ST_CLOSE: begin
                valid_next = 1'b1;
                if (cwin_reg == WINDOW_LIMIT) begin
                    new_ticks = WINDOW_LIMIT;
                end else begin
                    growth_next = grow_inc;
                    new_ticks   = grow_inc;
                    if (grow_inc == READY_WINDOW) ready_next = 1'b1;
                end
                ticks_next = new_ticks;
                cwin_next  = new_ticks;
                for (int i = 0; i < CHANNELS; i++) begin
                    ws_next[i] = '0;
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {rep_reg[4], rep_reg[3], rep_reg[2], rep_reg[1],
                                    rep_reg[0], drive_reg};
                    m_user_next  = {ready_reg, valid_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_high_reg <= REGULATE_HIGH_RESET;
            reg_low_reg  <= REGULATE_LOW_RESET;
            ceiling_reg  <= DAC_CEILING_RESET;
            for (int i = 0; i < CHANNELS - 1; i++) begin
                floor_reg[i] <= FLOOR_RESET;
            end
            drive_reg    <= DAC_START_RESET;
            count_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                acc_reg[i] <= '0;
                ws_reg[i]  <= '0;
                rep_reg[i] <= '0;
            end
            ticks_reg    <= WIN_W'(1);
            growth_reg   <= WIN_W'(1);
            cwin_reg     <= WIN_W'(1);
            ready_reg    <= 1'b0;
            valid_reg    <= 1'b0;
            ch_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            reg_high_reg <= reg_high_next;
            reg_low_reg  <= reg_low_next;
            ceiling_reg  <= ceiling_next;
            floor_reg    <= floor_next;
            drive_reg    <= drive_next;
            count_reg    <= count_next;
            acc_reg      <= acc_next;
            ws_reg       <= ws_next;
            rep_reg      <= rep_next;
            ticks_reg    <= ticks_next;
            growth_reg   <= growth_next;
            cwin_reg     <= cwin_next;
            ready_reg    <= ready_next;
            valid_reg    <= valid_next;
            ch_reg       <= ch_next;
            m_valid_reg  <= m_valid_next;
        end
        // payload, no reset
        smp_reg    <= smp_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

### hdl/rsa_checker.sv
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the ramped-average sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a taken word keeps the block busy for at least the next cycle
    `RSA_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")

    // stalled result word holds
    `RSA_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed under stall")

    // data_ready never drops once reported
    `RSA_ASSERT(a_ready_sticky, (m_tvalid && m_tready && m_tuser[1]) |=> (!m_tvalid || m_tuser[1]), "data_ready dropped")

    // reset empties the output register
    `RSA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind regulated_sampler_with_ramped_average rsa_checker u_rsa_checker (.*);

`default_nettype wire

### test/tb_regulated_sampler_with_ramped_average.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_regulated_sampler_with_ramped_average
// Stream-level test of the DAC regulator and growing-window averager.
// Words go in with random gaps. Each result word is checked field by field
// against an in-bench model of the level, accumulators and window.
// ----------------------------------------------------------------------------

module tb_regulated_sampler_with_ramped_average;
    import rsa_pkg::*;

    // ---------------------------------------------------------------- DUT I/O
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [15:0] signal, [31:16] anode, [47:32] cathode,
    // [63:48] bleeder anode, [79:64] bleeder cathode
    logic [79:0] s_tdata   = '0;
    // [0] operation (1 = tick)
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [15:0] dac_level, [31:16] signal avg, [47:32] anode avg,
    // [63:48] cathode avg, [79:64] bleeder anode avg, [95:80] bleeder cathode avg
    logic [95:0] m_tdata;
    // [0] report_valid, [1] data_ready
    logic [1:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data  = 16'd0;

    regulated_sampler_with_ramped_average DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------- expected results
    typedef struct packed {
        logic [15:0]      level;
        logic             report;
        logic [4:0][15:0] avg;     // [0] signal, then anode .. bleeder cathode
        logic             ready;
    } sample_result_t;

    sample_result_t pending_results[$];

    // model state: own copy of registers and block state
    logic [7:0][15:0] cfg_reg;
    logic [15:0]      lvl_now;
    logic [11:0]      n_acc;
    logic [4:0][27:0] chan_acc;
    logic [4:0][19:0] win_sum;
    logic [3:0]       ticks_left;
    logic [3:0]       win_growth;
    logic [3:0]       win_len;
    logic [4:0][15:0] avg_held;
    logic             ready_seen;

    // run control and bookkeeping
    int unsigned mismatches    = 0;
    int unsigned words_sent    = 0;
    int unsigned ticks_sent    = 0;
    int unsigned reports_seen  = 0;
    int unsigned sender_gap_pct = 15;
    bit          sink_gaps_off = 1'b0;

    // quotient with divide-by-zero giving zero, clipped to 16 bits
    function automatic logic [15:0] clipped_mean(input logic [31:0] num,
                                                 input logic [3:0] den);
        logic [31:0] q;
        q = (den == 4'd0) ? 32'd0 : num / {28'd0, den};
        return (q > 32'h0000_FFFF) ? 16'hFFFF : q[15:0];
    endfunction

    // One regulation step, then accumulate or tick; returns the result word.
    task automatic predict_result(input logic op, input logic [4:0][15:0] smp,
                                  output sample_result_t r);
        logic [4:0][15:0] s;
        logic [31:0]      t;
        logic [31:0]      m;
        logic [15:0]      a;
        logic             closed;
        int               ch;
        closed = 1'b0;
        for (ch = 0; ch < CHANNELS; ch++)
            s[ch] = smp[ch] & SAMPLE_MASK;

        // high threshold wins when both apply
        if (s[0] > cfg_reg[CFG_REGULATE_HIGH]) begin
            if (lvl_now != 16'd0)
                lvl_now = lvl_now - 16'd1;
        end else if (s[0] < cfg_reg[CFG_REGULATE_LOW]) begin
            // a level already above the ceiling is left where it is
            if (lvl_now < cfg_reg[CFG_DAC_CEILING])
                lvl_now = lvl_now + 16'd1;
        end

        if (op) begin
            ticks_left = ticks_left - 4'd1;
            for (ch = 0; ch < CHANNELS; ch++) begin
                m = (n_acc == '0) ? 32'd0 : {4'd0, chan_acc[ch]} / {20'd0, n_acc};
                t = {12'd0, win_sum[ch]} + m;
                win_sum[ch]  = (t > {12'd0, SUM_MAX}) ? SUM_MAX : t[19:0];
                chan_acc[ch] = '0;
            end
            n_acc = '0;
            if (ticks_left == 4'd0) begin
                closed = 1'b1;
                if (win_len == WINDOW_LIMIT) begin
                    ticks_left = WINDOW_LIMIT;
                end else begin
                    win_growth = win_growth + 4'd1;
                    ticks_left = win_growth;
                    if (ticks_left == READY_WINDOW)
                        ready_seen = 1'b1;
                end
                avg_held[0] = clipped_mean({12'd0, win_sum[0]} / {20'd0, SIGNAL_DIVISOR},
                                           win_len);
                for (ch = 1; ch < CHANNELS; ch++) begin
                    a = clipped_mean({12'd0, win_sum[ch]}, win_len);
                    avg_held[ch] = (a < cfg_reg[int'(CFG_ANODE_FLOOR) + ch - 1]) ? 16'd0 : a;
                end
                win_sum = '0;
                win_len = ticks_left;
            end
        end else begin
            for (ch = 0; ch < CHANNELS; ch++) begin
                t = {4'd0, chan_acc[ch]} + {16'd0, s[ch]};
                chan_acc[ch] = (t > {4'd0, ACC_MAX}) ? ACC_MAX : t[27:0];
            end
            if (n_acc < MAX_SAMPLES)
                n_acc = n_acc + 12'd1;
        end

        r.level  = lvl_now;
        r.report = closed;
        r.avg    = avg_held;
        r.ready  = ready_seen;
    endtask

    // --------------------------------------------------------- stimulus side
    // Sends one word; valid is left high so a following word goes back to back.
    task automatic send_word(input logic op, input logic [4:0][15:0] smp);
        sample_result_t r;
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_result(op, smp, r);
        pending_results.push_back(r);
        words_sent++;
        if (op)
            ticks_sent++;
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_reg[idx] = val;
        @(posedge aclk);
    endtask

    function automatic logic [4:0][15:0] random_samples();
        logic [4:0][15:0] v;
        int               ch;
        for (ch = 0; ch < CHANNELS; ch++) begin
            case ($urandom_range(15))
                0:       v[ch] = 16'h0000;
                1:       v[ch] = 16'hFFFF;
                default: v[ch] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    // ------------------------------------------------------------ sink side
    always @(posedge aclk)
        m_tready <= sink_gaps_off || ($urandom_range(99) >= 15);

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        end
    endtask

    // every accepted result word against the oldest expectation
    always @(posedge aclk) begin : result_check
        sample_result_t want;
        int             ch;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tuser[0])
                reports_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result word, expected none, actual level %0d",
                         $time, m_tdata[15:0]);
            end else begin
                want = pending_results.pop_front();
                compare_field("dac_level", want.level, m_tdata[15:0]);
                compare_field("report_valid", 16'(want.report), 16'(m_tuser[0]));
                for (ch = 0; ch < CHANNELS; ch++)
                    compare_field($sformatf("average ch%0d", ch), want.avg[ch],
                                  m_tdata[16 + 16*ch +: 16]);
                compare_field("data_ready", 16'(want.ready), 16'(m_tuser[1]));
            end
        end
    end

    // ------------------------------------------------------------------ tests
    // Tick with no samples straight after reset (closes the one-tick window),
    // then field extremes.
    task automatic test_empty_tick_and_extremes();
        send_word(1'b1, random_samples());
        send_word(1'b0, {5{16'h0000}});
        send_word(1'b0, {5{16'hFFFF}});
        send_word(1'b0, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        send_word(1'b0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        send_word(1'b1, random_samples());   // first tick of the two-tick window
        drain();
    endtask

    // Stepping up and down, both clamps, a level stranded above the ceiling,
    // and a dac_start write that must change nothing until a reset.
    task automatic test_regulation_limits();
        logic [4:0][15:0] smp;
        int               n;
        write_reg(CFG_REGULATE_LOW, 16'hFFFF);
        smp = random_samples();
        smp[0] = 16'd0;
        repeat (5) send_word(1'b0, smp);             // up to 5
        drain();
        write_reg(CFG_DAC_CEILING, 16'd2);
        repeat (2) send_word(1'b0, smp);             // stays above ceiling
        drain();
        write_reg(CFG_REGULATE_HIGH, 16'd0);
        smp[0] = 16'd1;                              // above high and below low
        repeat (3) send_word(1'b0, smp);             // high wins: down to 2
        smp[0] = 16'd0;
        repeat (2) send_word(1'b0, smp);             // up, but at ceiling
        smp[0] = 16'hFFFF;
        repeat (3) send_word(1'b0, smp);             // down to 0, holds at 0
        drain();
        write_reg(CFG_DAC_START, 16'd1234);
        smp[0] = 16'd40000;
        send_word(1'b0, smp);
        drain();
        write_reg(CFG_REGULATE_HIGH, REGULATE_HIGH_RESET);
        write_reg(CFG_REGULATE_LOW, REGULATE_LOW_RESET);
        write_reg(CFG_DAC_CEILING, DAC_CEILING_RESET);
        for (n = 0; n < 2; n++)
            send_word(1'b0, random_samples());
        drain();
    endtask

    // Floors: at the top value, at zero, one above and one equal to the mean.
    task automatic test_report_floors();
        logic [4:0][15:0] smp;
        write_reg(CFG_ANODE_FLOOR, 16'hFFFF);
        write_reg(CFG_CATHODE_FLOOR, 16'd0);
        write_reg(CFG_BLEEDER_ANODE_FLOOR, 16'd1000);
        write_reg(CFG_BLEEDER_CATHODE_FLOOR, 16'd1000);
        smp = {16'd1000, 16'd999, 16'd12345, 16'hFFFF, 16'd50000};
        // ticks until the current window closes
        forever begin
            send_word(1'b0, smp);
            send_word(1'b1, smp);
            if (pending_results[$].report)
                break;
        end
        drain();
    endtask

    // Well-formed runs (a few samples then a tick) with random content,
    // salted with stray words, over several register settings.
    task automatic test_random_windows(input int n_items);
        logic [7:0][15:0] vals;
        int               phase;
        int               sent;
        int               burst;
        int               k;
        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: vals = {{4{FLOOR_RESET}}, DAC_START_RESET, DAC_CEILING_RESET,
                           REGULATE_LOW_RESET, REGULATE_HIGH_RESET};
                1: vals = '0;
                2: vals = '1;
                default: begin
                    for (k = 0; k < 8; k++)
                        vals[k] = 16'($urandom);
                    if ($urandom_range(1))
                        vals[CFG_DAC_CEILING] = 16'($urandom_range(30));
                end
            endcase
            for (k = 0; k < 8; k++)
                write_reg(cfg_index_t'(k), vals[k]);
            // one phase runs flat out on both sides
            sender_gap_pct = (phase == 3) ? 0 : 15;
            sink_gaps_off  = (phase == 3);
            sent = 0;
            while (sent < n_items / 6) begin
                if ($urandom_range(99) < 10) begin
                    send_word(1'($urandom_range(1)), random_samples());
                    sent++;
                end else begin
                    burst = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
                    for (k = 0; k < burst; k++)
                        send_word(1'b0, random_samples());
                    send_word(1'b1, random_samples());
                    sent += burst + 1;
                end
                // now and then hold off until the pipe is empty
                if ($urandom_range(39) == 0)
                    drain();
            end
        end
        sender_gap_pct = 15;
        sink_gaps_off  = 1'b0;
    endtask

    // ------------------------------------------------------------- sequence
    initial begin
        // model reset: registers first, then the level from dac_start
        cfg_reg = {{4{FLOOR_RESET}}, DAC_START_RESET, DAC_CEILING_RESET,
                   REGULATE_LOW_RESET, REGULATE_HIGH_RESET};
        lvl_now    = cfg_reg[CFG_DAC_START];
        n_acc      = '0;
        chan_acc   = '0;
        win_sum    = '0;
        ticks_left = 4'd1;
        win_growth = 4'd1;
        win_len    = 4'd1;
        avg_held   = '0;
        ready_seen = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_tick_and_extremes();
        test_regulation_limits();
        test_report_floors();
        test_random_windows(850);

        drain();
        // longest word is a closing tick
        repeat (400) @(posedge aclk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d expected words never arrived, expected 0, actual %0d",
                     $time, pending_results.size(), pending_results.size());
        end

        $display("Covered %0d words (%0d ticks) and %0d window reports,",
                 words_sent, ticks_sent, reports_seen);
        $display("incl. an empty tick, level clamps, floors and six register settings.");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #80_000_000;
        $display("Timeout: result words stopped arriving");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/rsa_pkg.sv
hdl/rsa_divider.sv
hdl/regulated_sampler_with_ramped_average.sv
hdl/rsa_checker.sv
test/tb_regulated_sampler_with_ramped_average.sv
